// ===== hw/rtl/bsfd_pkg.sv =====
// shared types and constants for the box-smoothed frame difference motion unit
package bsfd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 10;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 9;

  // reset values of the registers
  localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd20;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd384;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd288;
  localparam int               MIN_DIM          = 3;

  // first interior line or column of the window centre plus one
  localparam int BORDER = 2;

  // 3x3 sum and floor divide by 9 through a reciprocal multiply
  localparam int               SUM_W      = 12;
  localparam int               RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] RECIP9   = 13'd7282;
  localparam int               RECIP_SHIFT = 16;
  localparam int               PROD_W     = SUM_W + RECIP_W;

  // control that rides along with one pixel through the pipeline
  typedef struct packed {
    logic             interior;
    logic             emit;
    logic             eof;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } tag_t;

endpackage

// ===== hw/rtl/bsfd_pix_if.sv =====
// pixel input channel
interface bsfd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

// ===== hw/rtl/bsfd_res_if.sv =====
// motion result channel
interface bsfd_res_if;
  logic       valid;
  logic       ready;
  logic       motion;
  logic [8:0] out_line;
  logic [8:0] out_column;
  logic       end_of_frame;

  modport source (output valid, output motion, output out_line, output out_column,
                  output end_of_frame, input ready);
  modport sink (input valid, input motion, input out_line, input out_column,
                input end_of_frame, output ready);
endinterface

// ===== hw/rtl/bsfd_window.sv =====
// line store, 3x3 window and window sum
module bsfd_window #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               acc,
  input  logic [bsfd_pkg::PIX_W-1:0]         px,
  input  logic [$clog2(MAX_WIDTH)-1:0]       col,
  input  logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] addr,
  input  bsfd_pkg::tag_t                     tag,
  output logic                               v3,
  output bsfd_pkg::tag_t                     tag3,
  output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] addr3,
  output logic [bsfd_pkg::SUM_W-1:0]         sum3
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int FAW  = $clog2(MAX_HEIGHT) + CW;
  localparam int PW   = bsfd_pkg::PIX_W;
  localparam int WORD = 2 * PW;

  // one word per column: line two above in the upper half, line one above in the lower
  logic [WORD-1:0] lmem [MAX_WIDTH];
  logic [WORD-1:0] rd_r;

  logic            v1_r;
  logic [PW-1:0]   px1_r;
  logic [CW-1:0]   col1_r;
  logic [FAW-1:0]  addr1_r;
  bsfd_pkg::tag_t  tag1_r;
  logic            fwd_r;
  logic [WORD-1:0] wlast_r;

  logic [WORD-1:0] word_eff;
  logic [WORD-1:0] wword;

  logic            v2_r;
  logic [FAW-1:0]  addr2_r;
  bsfd_pkg::tag_t  tag2_r;
  logic [PW-1:0]   win_r [9];
  logic [bsfd_pkg::SUM_W-1:0] sum_nxt;

  logic            v3_r;
  bsfd_pkg::tag_t  tag3_r;
  logic [FAW-1:0]  addr3_r;
  logic [bsfd_pkg::SUM_W-1:0] sum3_r;

  // line store read and write, one access each per transaction
  always_ff @(posedge clk) begin
    if (en && acc) begin
      rd_r <= lmem[col];
    end
    if (en && v1_r) begin
      lmem[col1_r] <= wword;
    end
  end

  // the word just written wins when the next pixel reads the same column
  assign word_eff = fwd_r ? wlast_r : rd_r;
  assign wword    = {word_eff[PW-1:0], px1_r};

  // stage 1: pixel with its line store column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= px;
      col1_r  <= col;
      addr1_r <= addr;
      tag1_r  <= tag;
      fwd_r   <= v1_r && acc && (col1_r == col);
      wlast_r <= wword;
    end
  end

  // stage 2: window shifts left and takes the new column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr2_r <= addr1_r;
      tag2_r  <= tag1_r;
      if (v1_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= word_eff[WORD-1:PW];
        win_r[5] <= word_eff[PW-1:0];
        win_r[8] <= px1_r;
      end
    end
  end

  // sum of the nine window taps
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      sum_nxt = sum_nxt + bsfd_pkg::SUM_W'(win_r[i]);
    end
  end

  // stage 3: registered window sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r  <= tag2_r;
      addr3_r <= addr2_r;
      sum3_r  <= sum_nxt;
    end
  end

  assign v3    = v3_r;
  assign tag3  = tag3_r;
  assign addr3 = addr3_r;
  assign sum3  = sum3_r;

endmodule

// ===== hw/rtl/bsfd_compare.sv =====
// box average, previous frame store and threshold compare
module bsfd_compare #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               v3,
  input  bsfd_pkg::tag_t                     tag3,
  input  logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] addr3,
  input  logic [bsfd_pkg::SUM_W-1:0]         sum3,
  input  logic [bsfd_pkg::PIX_W-1:0]         threshold,
  output logic                               out_valid,
  output logic                               motion,
  output logic [bsfd_pkg::POS_W-1:0]         out_line,
  output logic [bsfd_pkg::POS_W-1:0]         out_column,
  output logic                               end_of_frame
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int FAW    = $clog2(MAX_HEIGHT) + CW;
  localparam int FDEPTH = MAX_HEIGHT << CW;
  localparam int PW     = bsfd_pkg::PIX_W;

  // smoothed values of the last frame, line in the upper address bits
  logic [PW-1:0] fmem [FDEPTH];

  logic [bsfd_pkg::PROD_W-1:0] prod;
  logic            v4_r;
  bsfd_pkg::tag_t  tag4_r;
  logic [FAW-1:0]  addr4_r;
  logic [PW-1:0]   smooth4_r;
  logic [PW-1:0]   prev4_r;
  logic [PW-1:0]   diff;
  logic            motion_nxt;

  logic            out_valid_r;
  logic            motion_r;
  logic [bsfd_pkg::POS_W-1:0] line_r;
  logic [bsfd_pkg::POS_W-1:0] column_r;
  logic            eof_r;

  // floor of sum / 9 by reciprocal multiply
  assign prod = bsfd_pkg::PROD_W'(sum3) * bsfd_pkg::PROD_W'(bsfd_pkg::RECIP9);

  // frame store read for the stage 3 position, write of the stage 4 value
  always_ff @(posedge clk) begin
    if (en) begin
      prev4_r <= fmem[addr3];
      if (v4_r && tag4_r.interior) begin
        fmem[addr4_r] <= smooth4_r;
      end
    end
  end

  // stage 4: smoothed value and previous frame value side by side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r    <= tag3;
      addr4_r   <= addr3;
      smooth4_r <= prod[bsfd_pkg::RECIP_SHIFT +: PW];
    end
  end

  // absolute temporal difference against the threshold
  always_comb begin
    diff       = (smooth4_r > prev4_r) ? (smooth4_r - prev4_r) : (prev4_r - smooth4_r);
    motion_nxt = diff > threshold;
  end

  // output register, reloaded whenever the pipeline advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r && tag4_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      motion_r <= motion_nxt;
      line_r   <= tag4_r.line;
      column_r <= tag4_r.column;
      eof_r    <= tag4_r.eof;
    end
  end

  assign out_valid    = out_valid_r;
  assign motion       = motion_r;
  assign out_line     = line_r;
  assign out_column   = column_r;
  assign end_of_frame = eof_r;

endmodule

// ===== hw/rtl/box_smooth_frame_difference_motion_unit.sv =====
// top level of the box-smoothed frame difference motion unit
//
//   channel     dir   handshake          payload
//   in_stream   in    valid / ready      pixel[7:0], start_of_frame
//   out_stream  out   valid / ready      motion, out_line[8:0], out_column[8:0],
//                                        end_of_frame
//   cfg_*       in    cfg_we             cfg_index[1:0], cfg_data[9:0]
//
// one pixel per cycle while the pipeline is not held; a result reaches the output
// register through the line store read, window, sum and the average with frame
// store read stages, and leaves when out_stream.ready is high
// each cycle does at most one line store read and write and one frame store read and write
// rst_n is synchronous; it empties the pipeline and reloads the registers
// a full output register with out_stream.ready low holds every stage and drops
// in_stream.ready; pixels without a result pass through as bubbles
module box_smooth_frame_difference_motion_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bsfd_pix_if.sink                            in_stream,
  bsfd_res_if.source                          out_stream,
  input  logic                                cfg_we,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LW   = $clog2(MAX_HEIGHT);
  localparam int FAW  = LW + CW;
  localparam int CMPW = (CW + 1 > LW + 1) ?
                        ((CW + 1 > bsfd_pkg::DIM_W) ? CW + 1 : bsfd_pkg::DIM_W) :
                        ((LW + 1 > bsfd_pkg::DIM_W) ? LW + 1 : bsfd_pkg::DIM_W);

  logic [bsfd_pkg::PIX_W-1:0] thr_r;
  logic [bsfd_pkg::DIM_W-1:0] fw_r;
  logic [bsfd_pkg::DIM_W-1:0] fh_r;
  logic [bsfd_pkg::DIM_W-1:0] dim_nxt;
  logic                       pending_r;
  logic [CW-1:0]              col_r;
  logic [LW-1:0]              line_r;

  logic                       en;
  logic                       acc;
  logic                       restart;
  logic [CW-1:0]              col0;
  logic [LW-1:0]              line0;
  logic [CW:0]                col_inc;
  logic [LW:0]                line_inc;
  logic                       wrap_c;
  logic                       wrap_l;
  logic [FAW-1:0]             addr0;
  bsfd_pkg::tag_t             tag0;

  logic                       v3;
  bsfd_pkg::tag_t             tag3;
  logic [FAW-1:0]             addr3;
  logic [bsfd_pkg::SUM_W-1:0] sum3;
  logic                       res_valid;

  // the whole pipeline moves when the output register is free or being emptied
  assign en              = !res_valid || out_stream.ready;
  assign in_stream.ready = en;
  assign acc             = in_stream.valid && en;

  // geometry clamp on a configuration write
  always_comb begin
    if (cfg_data < bsfd_pkg::DIM_W'(bsfd_pkg::MIN_DIM)) begin
      dim_nxt = bsfd_pkg::DIM_W'(bsfd_pkg::MIN_DIM);
    end else if (cfg_index == bsfd_pkg::CFG_FRAME_WIDTH && 32'(cfg_data) > MAX_WIDTH) begin
      dim_nxt = bsfd_pkg::DIM_W'(MAX_WIDTH);
    end else if (cfg_index == bsfd_pkg::CFG_FRAME_HEIGHT && 32'(cfg_data) > MAX_HEIGHT) begin
      dim_nxt = bsfd_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      dim_nxt = cfg_data;
    end
  end

  // position of this pixel, back to the frame origin on a start mark or overrun
  always_comb begin
    restart = in_stream.start_of_frame ||
              (CMPW'(col_r) >= CMPW'(fw_r)) || (CMPW'(line_r) >= CMPW'(fh_r));
    col0     = restart ? '0 : col_r;
    line0    = restart ? '0 : line_r;
    col_inc  = {1'b0, col0} + (CW + 1)'(1);
    line_inc = {1'b0, line0} + (LW + 1)'(1);
    wrap_c   = CMPW'(col_inc) >= CMPW'(fw_r);
    wrap_l   = CMPW'(line_inc) >= CMPW'(fh_r);
    addr0    = {line0 - LW'(1), col0 - CW'(1)};

    tag0.interior = (line0 >= LW'(bsfd_pkg::BORDER)) && (col0 >= CW'(bsfd_pkg::BORDER));
    tag0.emit     = tag0.interior && !pending_r;
    tag0.eof      = (CMPW'(line_inc) == CMPW'(fh_r)) && (CMPW'(col_inc) == CMPW'(fw_r));
    tag0.line     = bsfd_pkg::POS_W'(line0 - LW'(1));
    tag0.column   = bsfd_pkg::POS_W'(col0 - CW'(1));
  end

  // registers, position counters and the first frame flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= bsfd_pkg::THRESHOLD_RST;
      fw_r      <= bsfd_pkg::DIM_W'(32'(bsfd_pkg::FRAME_WIDTH_RST) > MAX_WIDTH ?
                                    MAX_WIDTH : 32'(bsfd_pkg::FRAME_WIDTH_RST));
      fh_r      <= bsfd_pkg::DIM_W'(32'(bsfd_pkg::FRAME_HEIGHT_RST) > MAX_HEIGHT ?
                                    MAX_HEIGHT : 32'(bsfd_pkg::FRAME_HEIGHT_RST));
      pending_r <= 1'b1;
      col_r     <= '0;
      line_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsfd_pkg::CFG_THRESHOLD: begin
          thr_r     <= cfg_data[bsfd_pkg::PIX_W-1:0];
          pending_r <= 1'b1;
          col_r     <= '0;
          line_r    <= '0;
        end
        bsfd_pkg::CFG_FRAME_WIDTH: begin
          fw_r      <= dim_nxt;
          pending_r <= 1'b1;
          col_r     <= '0;
          line_r    <= '0;
        end
        bsfd_pkg::CFG_FRAME_HEIGHT: begin
          fh_r      <= dim_nxt;
          pending_r <= 1'b1;
          col_r     <= '0;
          line_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      if (wrap_c) begin
        col_r <= '0;
        if (wrap_l) begin
          line_r    <= '0;
          pending_r <= 1'b0;
        end else begin
          line_r <= line_inc[LW-1:0];
        end
      end else begin
        col_r  <= col_inc[CW-1:0];
        line_r <= line0;
      end
    end
  end

  bsfd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .acc   (acc),
    .px    (in_stream.pixel),
    .col   (col0),
    .addr  (addr0),
    .tag   (tag0),
    .v3    (v3),
    .tag3  (tag3),
    .addr3 (addr3),
    .sum3  (sum3)
  );

  bsfd_compare #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_compare (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .v3           (v3),
    .tag3         (tag3),
    .addr3        (addr3),
    .sum3         (sum3),
    .threshold    (thr_r),
    .out_valid    (res_valid),
    .motion       (out_stream.motion),
    .out_line     (out_stream.out_line),
    .out_column   (out_stream.out_column),
    .end_of_frame (out_stream.end_of_frame)
  );

  assign out_stream.valid = res_valid;

endmodule
